@@ hw/rtl/stereo_pan_mixer_soft_clip_assert.svh @@
// Assertion macros for the stereo pan mixer checker
`ifndef STEREO_PAN_MIXER_SOFT_CLIP_ASSERT_SVH
`define STEREO_PAN_MIXER_SOFT_CLIP_ASSERT_SVH

// same-cycle implication
`define SPMSC_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("spmsc assertion failed");

// next-cycle implication
`define SPMSC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("spmsc assertion failed");

`endif

@@ hw/rtl/spmsc_pkg.sv @@
// Shared types and constants for the stereo pan mixer
package spmsc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 9;
    localparam int PAN_W    = 10;
    localparam int VM_W     = 18;
    localparam int GAIN_W   = 10;
    localparam int CONTR_W  = 19;
    localparam int ACC_W    = 32;

    localparam logic [VOL_W-1:0] MASTER_RESET = 9'd256;

    localparam logic signed [ACC_W:0] KNEE    = 33'sd28000;
    localparam logic signed [ACC_W:0] OUT_MAX = 33'sd32767;
    localparam logic signed [ACC_W:0] OUT_MIN = -33'sd32768;

    typedef struct packed {
        logic load;
        logic gain;
        logic mul;
        logic acc;
        logic clip;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_stall;
    } status_t;

endpackage

@@ hw/rtl/spmsc_in_if.sv @@
// Source channel: one source's stereo sample pair with volume and pan
interface spmsc_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [spmsc_pkg::SAMPLE_W-1:0]   left_sample;
    logic signed [spmsc_pkg::SAMPLE_W-1:0]   right_sample;
    logic        [spmsc_pkg::VOL_W-1:0]      source_volume;
    logic signed [spmsc_pkg::PAN_W-1:0]      pan;
    logic                                    pan_bypass;
    logic                                    last_source;

    modport source (
        output valid, left_sample, right_sample, source_volume, pan, pan_bypass,
               last_source,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample, source_volume, pan, pan_bypass,
               last_source,
        output ready
    );
endinterface

@@ hw/rtl/spmsc_out_if.sv @@
// Frame channel: one soft-clipped stereo output frame
interface spmsc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [spmsc_pkg::SAMPLE_W-1:0] left_out;
    logic signed [spmsc_pkg::SAMPLE_W-1:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

@@ hw/rtl/stereo_pan_mixer_soft_clip.sv @@
// Stereo pan mixer with soft clip: top level
// Each source transfer passes through input/volume, gain, scale and accumulate steps.
// A source marked last then goes on to soft clip into the output register;
// its frame is valid once the clip step has written that register.
// The next source is taken while a frame waits at the output; the clip step waits
// only if an earlier frame is still held. Reset clears accumulators, master = 256.
module stereo_pan_mixer_soft_clip (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        main_gain_we,
    input  logic [spmsc_pkg::VOL_W-1:0] main_gain,
    spmsc_in_if.sink                    samples,
    spmsc_out_if.source                 frames
);

    spmsc_pkg::cmd_t    cmd;
    spmsc_pkg::status_t status;

    spmsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    spmsc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .main_gain_we (main_gain_we),
        .main_gain    (main_gain),
        .samples      (samples),
        .frames       (frames),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

@@ hw/rtl/spmsc_ctrl.sv @@
// Sequencing state machine for the stereo pan mixer
module spmsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  spmsc_pkg::status_t status,
    output spmsc_pkg::cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GAIN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_CLIP = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? ST_CLIP : ST_IDLE;
            end
            ST_CLIP:
            begin
                if (!status.out_stall)
                begin
                    cmd.clip   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/spmsc_datapath.sv @@
// Gain, scale, accumulate and soft-clip datapath
module spmsc_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               main_gain_we,
    input  logic [spmsc_pkg::VOL_W-1:0]        main_gain,
    spmsc_in_if.sink                           samples,
    spmsc_out_if.source                        frames,
    input  spmsc_pkg::cmd_t                    cmd,
    output spmsc_pkg::status_t                 status
);

    logic        [spmsc_pkg::VOL_W-1:0]    master_reg;
    logic signed [spmsc_pkg::SAMPLE_W-1:0] ls_reg;
    logic signed [spmsc_pkg::SAMPLE_W-1:0] rs_reg;
    logic signed [spmsc_pkg::PAN_W-1:0]    pan_reg;
    logic                                  byp_reg;
    logic                                  last_reg;
    logic        [spmsc_pkg::VM_W-1:0]     vm_reg;
    logic        [spmsc_pkg::GAIN_W-1:0]   gl_reg;
    logic        [spmsc_pkg::GAIN_W-1:0]   gr_reg;
    logic signed [spmsc_pkg::CONTR_W-1:0]  cl_reg;
    logic signed [spmsc_pkg::CONTR_W-1:0]  cr_reg;
    logic signed [spmsc_pkg::ACC_W-1:0]    accl_reg;
    logic signed [spmsc_pkg::ACC_W-1:0]    accr_reg;
    logic signed [spmsc_pkg::SAMPLE_W-1:0] outl_reg;
    logic signed [spmsc_pkg::SAMPLE_W-1:0] outr_reg;
    logic                                  ovalid_reg;

    logic [7:0]  q;
    logic [8:0]  wl;
    logic [8:0]  wr;
    logic [26:0] pl;
    logic [26:0] pr;
    logic signed [26:0] ml;
    logic signed [26:0] mr;

    function automatic logic signed [spmsc_pkg::SAMPLE_W-1:0] knee_compress(
        input logic signed [spmsc_pkg::ACC_W-1:0] x
    );
        logic signed [spmsc_pkg::ACC_W:0] xs;
        logic signed [spmsc_pkg::ACC_W:0] nx;
        logic signed [spmsc_pkg::ACC_W:0] y;
        xs = {x[spmsc_pkg::ACC_W-1], x};
        nx = -xs;
        y  = xs;
        if (xs > spmsc_pkg::KNEE)
        begin
            y = spmsc_pkg::KNEE + ((xs - spmsc_pkg::KNEE) >>> 2);
        end
        else if (xs < -spmsc_pkg::KNEE)
        begin
            y = -(spmsc_pkg::KNEE + ((nx - spmsc_pkg::KNEE) >>> 2));
        end
        if (y > spmsc_pkg::OUT_MAX)
        begin
            y = spmsc_pkg::OUT_MAX;
        end
        if (y < spmsc_pkg::OUT_MIN)
        begin
            y = spmsc_pkg::OUT_MIN;
        end
        return y[spmsc_pkg::SAMPLE_W-1:0];
    endfunction

    // pan clamped to +-256, then offset and quartered
    always_comb
    begin
        q = 8'd0;
        if (pan_reg <= -10'sd256)
        begin
            q = 8'd0;
        end
        else if (pan_reg >= 10'sd256)
        begin
            q = 8'd128;
        end
        else
        begin
            q = 8'(10'(pan_reg + 10'sd256) >> 2);
        end
        wl = 9'd256 - {1'b0, q};
        wr = 9'd128 + {1'b0, q};
        pl = 27'(wl) * 27'(vm_reg);
        pr = 27'(wr) * 27'(vm_reg);
        ml = 27'(ls_reg) * 27'(signed'({1'b0, gl_reg}));
        mr = 27'(rs_reg) * 27'(signed'({1'b0, gr_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= spmsc_pkg::MASTER_RESET;
            accl_reg   <= '0;
            accr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (main_gain_we)
            begin
                master_reg <= main_gain;
            end
            if (cmd.acc)
            begin
                accl_reg <= accl_reg + spmsc_pkg::ACC_W'(cl_reg);
                accr_reg <= accr_reg + spmsc_pkg::ACC_W'(cr_reg);
            end
            else if (cmd.clip)
            begin
                accl_reg <= '0;
                accr_reg <= '0;
            end
            if (cmd.clip)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (frames.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ls_reg   <= samples.left_sample;
            rs_reg   <= samples.right_sample;
            pan_reg  <= samples.pan;
            byp_reg  <= samples.pan_bypass;
            last_reg <= samples.last_source;
            vm_reg   <= spmsc_pkg::VM_W'(samples.source_volume) * spmsc_pkg::VM_W'(master_reg);
        end
        if (cmd.gain)
        begin
            if (byp_reg)
            begin
                gl_reg <= vm_reg[17:8];
                gr_reg <= vm_reg[17:8];
            end
            else
            begin
                gl_reg <= pl[25:16];
                gr_reg <= pr[25:16];
            end
        end
        if (cmd.mul)
        begin
            cl_reg <= ml[26:8];
            cr_reg <= mr[26:8];
        end
        if (cmd.clip)
        begin
            outl_reg <= knee_compress(accl_reg);
            outr_reg <= knee_compress(accr_reg);
        end
    end

    assign status.last      = last_reg;
    assign status.out_stall = ovalid_reg & ~frames.ready;

    assign frames.valid     = ovalid_reg;
    assign frames.left_out  = outl_reg;
    assign frames.right_out = outr_reg;

endmodule

@@ hw/rtl/spmsc_checker.sv @@
// Port-level checker for the stereo pan mixer, bound to the top level
`include "stereo_pan_mixer_soft_clip_assert.svh"

module spmsc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready
);

    logic in_xfer;
    logic last_xfer;

    assign in_xfer   = in_valid && in_ready;
    assign last_xfer = in_xfer && in_last;

    `SPMSC_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, !in_ready)
    `SPMSC_ASSERT_NEXT(a_ready_after_plain, clk, rst_n, in_xfer && !in_last, ##3 in_ready)
    `SPMSC_ASSERT_NEXT(a_busy_after_last, clk, rst_n, last_xfer, ##3 !in_ready)
    `SPMSC_ASSERT_IMPLY(a_frame_from_last, clk, rst_n, $rose(out_valid), $past(last_xfer, 5))
    `SPMSC_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind stereo_pan_mixer_soft_clip spmsc_checker u_spmsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_last   (samples.last_source),
    .out_valid (frames.valid),
    .out_ready (frames.ready)
);
